### rtl/vbcl_pkg.sv
// ----------------------------------------------------------------------------
// vbcl_pkg
// Shared types and constants of the volume brick coordinate lookup.
// ----------------------------------------------------------------------------
package vbcl_pkg;

  localparam int NUM_AXES   = 3;
  localparam int POS_W      = 40;
  localparam int DIFF_W     = 41;
  localparam int SCALE_W    = 42;
  localparam int DIMS_W     = 30;
  localparam int DIM_W      = 10;
  localparam int SIZE_W     = 6;
  localparam int ENTRY_W    = 32;
  localparam int INDEX_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 42;
  localparam int FRAC_W     = 16;
  localparam int CELL_W     = 26;
  localparam int PROD_W     = 50;
  localparam int ROW_W      = 20;
  localparam int FLAT_W     = 30;
  localparam int LEVEL_W    = 8;
  localparam int OFF_W      = 8;
  localparam int MB_W       = 30;
  localparam int COORD_W    = 30;
  localparam int STATUS_W   = 2;

  localparam logic [CELL_W-1:0] CLAMP_EPS = 26'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_SCALE_X    = 3'd3,
    REG_SCALE_Y    = 3'd4,
    REG_SCALE_Z    = 3'd5,
    REG_GRID_DIMS  = 3'd6,
    REG_BRICK_SIZE = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_LEVEL_ZERO  = 2'd1,
    ST_RANGE       = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][FRAC_W-1:0] frac;
    logic [NUM_AXES-1:0][OFF_W-1:0]  off;
    logic [LEVEL_W-1:0]              level;
    logic                            range_err;
  } div1_side_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][OFF_W-1:0]  off;
    logic [LEVEL_W-1:0]              level;
    logic                            range_err;
  } div2_side_t;

endpackage

### rtl/vbcl_div.sv
// ----------------------------------------------------------------------------
// vbcl_div
// Pipelined restoring divider, one quotient bit per stage, lanes share the
// divisor and a sideband word that travels with them.
// ----------------------------------------------------------------------------
module vbcl_div #(
  parameter int NW    = 10,
  parameter int DW    = 8,
  parameter int LANES = 3,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [SW-1:0]              side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [LANES-1:0][DW-1:0]   rem,
  output logic [SW-1:0]              side_out
);

  logic                     vld   [NW];
  logic [LANES-1:0][NW-1:0] n_r   [NW];
  logic [LANES-1:0][DW-1:0] r_r   [NW];
  logic [DW-1:0]            d_r   [NW];
  logic [SW-1:0]            s_r   [NW];

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic                     vld_src;
    logic [LANES-1:0][NW-1:0] n_src;
    logic [LANES-1:0][DW-1:0] r_src;
    logic [DW-1:0]            d_src;
    logic [SW-1:0]            s_src;
    logic [LANES-1:0][NW-1:0] n_next;
    logic [LANES-1:0][DW-1:0] r_next;

    if (s == 0) begin : g_first
      assign vld_src = in_valid;
      assign n_src   = num;
      assign r_src   = '0;
      assign d_src   = den;
      assign s_src   = side;
    end else begin : g_later
      assign vld_src = vld[s-1];
      assign n_src   = n_r[s-1];
      assign r_src   = r_r[s-1];
      assign d_src   = d_r[s-1];
      assign s_src   = s_r[s-1];
    end

    always_comb begin
      logic [DW:0] trial;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        trial = {r_src[l], n_src[l][NW-1]};
        if (trial >= {1'b0, d_src}) begin
          r_next[l] = DW'(trial - {1'b0, d_src});
          n_next[l] = {n_src[l][NW-2:0], 1'b1};
        end else begin
          r_next[l] = trial[DW-1:0];
          n_next[l] = {n_src[l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s] <= n_next;
        r_r[s] <= r_next;
        d_r[s] <= d_src;
        s_r[s] <= s_src;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = n_r[NW-1];
  assign rem       = r_r[NW-1];
  assign side_out  = s_r[NW-1];

endmodule

### rtl/volume_brick_coordinate_lookup_unit.sv
// ----------------------------------------------------------------------------
// volume_brick_coordinate_lookup_unit
// Maps a world position to a brick texture coordinate through a sparse
// indirection table; write transactions load table entries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | func, table_index, entry_data, pos_x/y/z
//  rsp     | out       | rsp_valid / rsp_stall  | brick_coord_x/y/z, entry_level, status
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One transaction per cycle while rsp is not stalled; a lookup's result passes
//  through 50 register stages, set mostly by the two bit-serial divider
//  pipelines (10 and 30 stages).
//  Table writes commit in the seventh stage, in order with lookups.
//  The whole pipeline holds while a result sits stalled on rsp.
//  Synchronous reset clears valid bits and configuration registers (brick
//  size resets to 4); the table is not cleared.
// ----------------------------------------------------------------------------
module volume_brick_coordinate_lookup_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                func,
  input  logic [vbcl_pkg::INDEX_W-1:0]        table_index,
  input  logic [vbcl_pkg::ENTRY_W-1:0]        entry_data,
  input  logic signed [vbcl_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vbcl_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vbcl_pkg::POS_W-1:0]   pos_z,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [vbcl_pkg::COORD_W-1:0]        brick_coord_x,
  output logic [vbcl_pkg::COORD_W-1:0]        brick_coord_y,
  output logic [vbcl_pkg::COORD_W-1:0]        brick_coord_z,
  output logic [vbcl_pkg::LEVEL_W-1:0]        entry_level,
  output logic [vbcl_pkg::STATUS_W-1:0]       status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vbcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vbcl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NA  = vbcl_pkg::NUM_AXES;
  localparam int FW  = vbcl_pkg::FRAC_W;
  localparam int CW  = vbcl_pkg::CELL_W;
  localparam int DMW = vbcl_pkg::DIM_W;
  localparam int S1W = $bits(vbcl_pkg::div1_side_t);
  localparam int S2W = $bits(vbcl_pkg::div2_side_t);

  // configuration
  logic [vbcl_pkg::POS_W-1:0]   origin [NA];
  logic [vbcl_pkg::SCALE_W-1:0] scale  [NA];
  logic [vbcl_pkg::DIMS_W-1:0]  grid_dims;
  logic [vbcl_pkg::SIZE_W-1:0]  brick_size;
  logic [DMW-1:0]               dim    [NA];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NA; l++) begin
        origin[l] <= '0;
        scale[l]  <= '0;
      end
      grid_dims  <= '0;
      brick_size <= vbcl_pkg::SIZE_W'(4);
    end else if (cfg_valid) begin
      unique case (vbcl_pkg::cfg_reg_t'(cfg_index))
        vbcl_pkg::REG_ORIGIN_X:   origin[0]  <= cfg_data[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_ORIGIN_Y:   origin[1]  <= cfg_data[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_ORIGIN_Z:   origin[2]  <= cfg_data[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_SCALE_X:    scale[0]   <= cfg_data[vbcl_pkg::SCALE_W-1:0];
        vbcl_pkg::REG_SCALE_Y:    scale[1]   <= cfg_data[vbcl_pkg::SCALE_W-1:0];
        vbcl_pkg::REG_SCALE_Z:    scale[2]   <= cfg_data[vbcl_pkg::SCALE_W-1:0];
        vbcl_pkg::REG_GRID_DIMS:  grid_dims  <= cfg_data[vbcl_pkg::DIMS_W-1:0];
        vbcl_pkg::REG_BRICK_SIZE: brick_size <= cfg_data[vbcl_pkg::SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < NA; l++) begin
      dim[l] = grid_dims[l*DMW +: DMW];
    end
  end

  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  logic [vbcl_pkg::POS_W-1:0] pos [NA];
  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // stage a: offset from origin
  logic [vbcl_pkg::POS_W-1:0]  d_next [NA];
  logic                        a_valid, a_func, a_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] a_index;
  logic [vbcl_pkg::ENTRY_W-1:0] a_data;
  logic [vbcl_pkg::POS_W-1:0]  a_d [NA];

  always_comb begin
    logic [vbcl_pkg::DIFF_W-1:0] diff;
    diff = '0;
    for (int l = 0; l < NA; l++) begin
      diff = {pos[l][vbcl_pkg::POS_W-1], pos[l]}
           - {origin[l][vbcl_pkg::POS_W-1], origin[l]};
      if (!diff[vbcl_pkg::DIFF_W-1] && diff != '0) begin
        d_next[l] = diff[vbcl_pkg::POS_W-1:0];
      end else begin
        d_next[l] = '0;
      end
    end
  end

  // stage b: partial products
  logic                         b_valid, b_func, b_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] b_index;
  logic [vbcl_pkg::ENTRY_W-1:0] b_data;
  logic [17:0]                  b_hh [NA];
  logic [39:0]                  b_hl [NA];
  logic [41:0]                  b_lh [NA];
  logic [31:0]                  b_ll [NA];
  logic [17:0]                  hh_next [NA];
  logic [39:0]                  hl_next [NA];
  logic [41:0]                  lh_next [NA];
  logic [31:0]                  ll_next [NA];

  always_comb begin
    logic [63:0] ll;
    ll = '0;
    for (int l = 0; l < NA; l++) begin
      hh_next[l] = {10'b0, a_d[l][39:32]} * {8'b0, scale[l][41:32]};
      hl_next[l] = {32'b0, a_d[l][39:32]} * {8'b0, scale[l][31:0]};
      lh_next[l] = {10'b0, a_d[l][31:0]} * {32'b0, scale[l][41:32]};
      ll         = {32'b0, a_d[l][31:0]} * {32'b0, scale[l][31:0]};
      ll_next[l] = ll[63:32];
    end
  end

  // stage c: product sum
  logic                         c_valid, c_func, c_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] c_index;
  logic [vbcl_pkg::ENTRY_W-1:0] c_data;
  logic [vbcl_pkg::PROD_W-1:0]  c_prod [NA];
  logic [vbcl_pkg::PROD_W-1:0]  prod_next [NA];

  always_comb begin
    for (int l = 0; l < NA; l++) begin
      prod_next[l] = {b_hh[l], 32'b0} + vbcl_pkg::PROD_W'(b_hl[l])
                   + vbcl_pkg::PROD_W'(b_lh[l]) + vbcl_pkg::PROD_W'(b_ll[l]);
    end
  end

  // stage d: clamp
  logic                         d_valid, d_func, d_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] d_index;
  logic [vbcl_pkg::ENTRY_W-1:0] d_data;
  logic [CW-1:0]                d_cell [NA];
  logic [CW-1:0]                cell_next [NA];

  always_comb begin
    logic [CW-1:0] upper;
    upper = '0;
    for (int l = 0; l < NA; l++) begin
      upper = {dim[l], {FW{1'b0}}} - vbcl_pkg::CLAMP_EPS;
      if (c_prod[l] < vbcl_pkg::PROD_W'(upper)) begin
        cell_next[l] = c_prod[l][CW-1:0];
      end else begin
        cell_next[l] = upper;
      end
    end
  end

  // stage e: row index
  logic                         e_valid, e_func, e_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] e_index;
  logic [vbcl_pkg::ENTRY_W-1:0] e_data;
  logic [CW-1:0]                e_cell [NA];
  logic [vbcl_pkg::ROW_W-1:0]   e_row;
  logic [vbcl_pkg::ROW_W-1:0]   row_next;

  assign row_next = vbcl_pkg::ROW_W'(d_cell[2][CW-1:FW] * dim[1])
                  + vbcl_pkg::ROW_W'(d_cell[1][CW-1:FW]);

  // stage f: flat index
  logic                         f_valid, f_func, f_dim_zero;
  logic [vbcl_pkg::INDEX_W-1:0] f_index;
  logic [vbcl_pkg::ENTRY_W-1:0] f_data;
  logic [CW-1:0]                f_cell [NA];
  logic [vbcl_pkg::FLAT_W-1:0]  f_flat;
  logic [vbcl_pkg::FLAT_W-1:0]  flat_next;

  assign flat_next = vbcl_pkg::FLAT_W'(e_row * dim[0])
                   + vbcl_pkg::FLAT_W'(e_cell[0][CW-1:FW]);

  // stage g: table access
  logic                         g_valid, g_func, g_range_err;
  logic [vbcl_pkg::INDEX_W-1:0] g_index;
  logic [vbcl_pkg::ENTRY_W-1:0] g_data;
  logic [CW-1:0]                g_cell [NA];
  logic [AW-1:0]                g_raddr;
  logic [31:0]                  widx;
  logic [31:0]                  flat_ext;

  assign widx     = 32'(g_index);
  assign flat_ext = 32'(f_flat);

  logic [vbcl_pkg::ENTRY_W-1:0] table_mem [TABLE_DEPTH];

  // stage h: entry read
  logic                         h_valid, h_range_err;
  logic [CW-1:0]                h_cell [NA];
  logic [vbcl_pkg::ENTRY_W-1:0] h_entry;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (g_valid && g_func == vbcl_pkg::FUNC_WRITE && widx < 32'(TABLE_DEPTH)) begin
        table_mem[widx[AW-1:0]] <= g_data;
      end
      h_entry <= table_mem[g_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= req_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
      h_valid <= g_valid && g_func == vbcl_pkg::FUNC_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_func     <= func;
      a_index    <= table_index;
      a_data     <= entry_data;
      a_dim_zero <= (dim[0] == '0) || (dim[1] == '0) || (dim[2] == '0);
      b_func     <= a_func;
      b_index    <= a_index;
      b_data     <= a_data;
      b_dim_zero <= a_dim_zero;
      c_func     <= b_func;
      c_index    <= b_index;
      c_data     <= b_data;
      c_dim_zero <= b_dim_zero;
      d_func     <= c_func;
      d_index    <= c_index;
      d_data     <= c_data;
      d_dim_zero <= c_dim_zero;
      e_func     <= d_func;
      e_index    <= d_index;
      e_data     <= d_data;
      e_dim_zero <= d_dim_zero;
      e_row      <= row_next;
      f_func     <= e_func;
      f_index    <= e_index;
      f_data     <= e_data;
      f_dim_zero <= e_dim_zero;
      f_flat     <= flat_next;
      g_func     <= f_func;
      g_index    <= f_index;
      g_data     <= f_data;
      g_range_err <= f_dim_zero || (flat_ext >= 32'(TABLE_DEPTH));
      g_raddr    <= f_flat[AW-1:0];
      h_range_err <= g_range_err;
      for (int l = 0; l < NA; l++) begin
        a_d[l]    <= d_next[l];
        b_hh[l]   <= hh_next[l];
        b_hl[l]   <= hl_next[l];
        b_lh[l]   <= lh_next[l];
        b_ll[l]   <= ll_next[l];
        c_prod[l] <= prod_next[l];
        d_cell[l] <= cell_next[l];
        e_cell[l] <= d_cell[l];
        f_cell[l] <= e_cell[l];
        g_cell[l] <= f_cell[l];
        h_cell[l] <= g_cell[l];
      end
    end
  end

  // cell mod level
  logic [NA-1:0][DMW-1:0]              div1_num;
  vbcl_pkg::div1_side_t                div1_side;
  logic                                div1_valid;
  logic [NA-1:0][DMW-1:0]              div1_quo;
  logic [NA-1:0][vbcl_pkg::LEVEL_W-1:0] div1_rem;
  logic [S1W-1:0]                      div1_side_raw;
  vbcl_pkg::div1_side_t                div1_out;

  always_comb begin
    div1_side.level     = h_entry[31:24];
    div1_side.range_err = h_range_err;
    for (int l = 0; l < NA; l++) begin
      div1_num[l]       = h_cell[l][CW-1:FW];
      div1_side.frac[l] = h_cell[l][FW-1:0];
      div1_side.off[l]  = h_entry[l*vbcl_pkg::OFF_W +: vbcl_pkg::OFF_W];
    end
  end

  vbcl_div #(
    .NW    (DMW),
    .DW    (vbcl_pkg::LEVEL_W),
    .LANES (NA),
    .SW    (S1W)
  ) u_div_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (h_valid),
    .num       (div1_num),
    .den       (h_entry[31:24]),
    .side      (div1_side),
    .out_valid (div1_valid),
    .quo       (div1_quo),
    .rem       (div1_rem),
    .side_out  (div1_side_raw)
  );

  assign div1_out = vbcl_pkg::div1_side_t'(div1_side_raw);

  // stage m: remainder times brick size
  logic                                m_valid;
  logic [NA-1:0][vbcl_pkg::MB_W-1:0]   m_mb;
  vbcl_pkg::div2_side_t                m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= div1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side.off       <= div1_out.off;
      m_side.level     <= div1_out.level;
      m_side.range_err <= div1_out.range_err;
      for (int l = 0; l < NA; l++) begin
        m_mb[l] <= vbcl_pkg::MB_W'({div1_rem[l], div1_out.frac[l]})
                 * vbcl_pkg::MB_W'(brick_size);
      end
    end
  end

  // fraction term
  logic                                div2_valid;
  logic [NA-1:0][vbcl_pkg::MB_W-1:0]   div2_quo;
  logic [NA-1:0][vbcl_pkg::LEVEL_W-1:0] div2_rem;
  logic [S2W-1:0]                      div2_side_raw;
  vbcl_pkg::div2_side_t                div2_out;

  vbcl_div #(
    .NW    (vbcl_pkg::MB_W),
    .DW    (vbcl_pkg::LEVEL_W),
    .LANES (NA),
    .SW    (S2W)
  ) u_div_frac (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (m_valid),
    .num       (m_mb),
    .den       (m_side.level),
    .side      (m_side),
    .out_valid (div2_valid),
    .quo       (div2_quo),
    .rem       (div2_rem),
    .side_out  (div2_side_raw)
  );

  assign div2_out = vbcl_pkg::div2_side_t'(div2_side_raw);

  // output stage
  logic [vbcl_pkg::COORD_W-1:0] coord_next [NA];
  logic [vbcl_pkg::LEVEL_W-1:0] level_next;
  logic [vbcl_pkg::STATUS_W-1:0] status_next;

  always_comb begin
    logic [14:0]                 base;
    logic [vbcl_pkg::MB_W-1:0]   fterm;
    logic [30:0]                 sum;
    base  = '0;
    fterm = '0;
    sum   = '0;
    for (int l = 0; l < NA; l++) begin
      base  = 15'(div2_out.off[l]) * (15'(brick_size) + 15'd1);
      fterm = (div2_out.level != '0) ? div2_quo[l] : '0;
      sum   = {base, {FW{1'b0}}} + 31'(fterm);
      coord_next[l] = div2_out.range_err ? '0 : sum[vbcl_pkg::COORD_W-1:0];
    end
    if (div2_out.range_err) begin
      level_next  = '0;
      status_next = vbcl_pkg::ST_RANGE;
    end else if (div2_out.level == '0) begin
      level_next  = '0;
      status_next = vbcl_pkg::ST_LEVEL_ZERO;
    end else begin
      level_next  = div2_out.level;
      status_next = vbcl_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= div2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      brick_coord_x <= coord_next[0];
      brick_coord_y <= coord_next[1];
      brick_coord_z <= coord_next[2];
      entry_level   <= level_next;
      status        <= status_next;
    end
  end

endmodule

### rtl/vbcl_check.sv
// ----------------------------------------------------------------------------
// vbcl_check
// Port-level checks on the lookup result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vbcl_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input logic [vbcl_pkg::COORD_W-1:0]      brick_coord_x,
  input logic [vbcl_pkg::COORD_W-1:0]      brick_coord_y,
  input logic [vbcl_pkg::COORD_W-1:0]      brick_coord_z,
  input logic [vbcl_pkg::LEVEL_W-1:0]      entry_level,
  input logic [vbcl_pkg::STATUS_W-1:0]     status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
      && $stable(brick_coord_x) && $stable(entry_level))
    else $error("stalled transaction changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == vbcl_pkg::ST_OK || status == vbcl_pkg::ST_LEVEL_ZERO
      || status == vbcl_pkg::ST_RANGE)
    else $error("undefined status code");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == vbcl_pkg::ST_RANGE |-> brick_coord_x == '0
      && brick_coord_y == '0 && brick_coord_z == '0 && entry_level == '0)
    else $error("range error with nonzero payload");

  a_level_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != vbcl_pkg::ST_RANGE
      |-> (status == vbcl_pkg::ST_LEVEL_ZERO) == (entry_level == '0))
    else $error("level and status disagree");

endmodule

bind volume_brick_coordinate_lookup_unit vbcl_check u_vbcl_check (.*);

### test/tb_volume_brick_coordinate_lookup_unit.sv
// ----------------------------------------------------------------------------
// tb_volume_brick_coordinate_lookup_unit
// Loads indirection entries and issues lookups under several register
// settings and random flow control, predicts every brick coordinate and
// status, and compares each response in order against the prediction.
// ----------------------------------------------------------------------------
module tb_volume_brick_coordinate_lookup_unit;

  localparam int DEPTH = 4096;
  localparam int LATENCY = 60;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [vbcl_pkg::COORD_W-1:0] cx;
    logic [vbcl_pkg::COORD_W-1:0] cy;
    logic [vbcl_pkg::COORD_W-1:0] cz;
    logic [vbcl_pkg::LEVEL_W-1:0] level;
    logic [vbcl_pkg::STATUS_W-1:0] st;
  } brick_rsp_t;

  class lookup_scoreboard;
    logic signed [vbcl_pkg::POS_W-1:0] org [3];
    logic [vbcl_pkg::SCALE_W-1:0] scl [3];
    logic [vbcl_pkg::DIMS_W-1:0] dims;
    logic [vbcl_pkg::SIZE_W-1:0] bsize;
    logic [vbcl_pkg::ENTRY_W-1:0] entries [DEPTH];
    brick_rsp_t pending [$];
    int mismatches;

    function new();
      for (int i = 0; i < 3; i++) begin
        org[i] = '0;
        scl[i] = '0;
      end
      dims = '0;
      bsize = 6'd4;
      mismatches = 0;
    endfunction

    function void set_reg(vbcl_pkg::cfg_reg_t r, logic [vbcl_pkg::CFG_DATA_W-1:0] v);
      case (r)
        vbcl_pkg::REG_ORIGIN_X: org[0] = v[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_ORIGIN_Y: org[1] = v[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_ORIGIN_Z: org[2] = v[vbcl_pkg::POS_W-1:0];
        vbcl_pkg::REG_SCALE_X: scl[0] = v;
        vbcl_pkg::REG_SCALE_Y: scl[1] = v;
        vbcl_pkg::REG_SCALE_Z: scl[2] = v;
        vbcl_pkg::REG_GRID_DIMS: dims = v[vbcl_pkg::DIMS_W-1:0];
        vbcl_pkg::REG_BRICK_SIZE: bsize = v[vbcl_pkg::SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] cell_coord(logic signed [vbcl_pkg::POS_W-1:0] p, int a,
                                     logic [63:0] dim);
      logic signed [63:0] diff;
      logic [127:0] prod;
      logic [63:0] upper;
      diff = 64'(p) - 64'(org[a]);
      upper = (dim << 16) - 64'd655;
      if (diff <= 0) return '0;
      prod = (128'(diff) * 128'(scl[a])) >> 32;
      return (prod < 128'(upper)) ? prod[63:0] : upper;
    endfunction

    function logic [vbcl_pkg::COORD_W-1:0] tex_coord(logic [63:0] c, logic [63:0] off,
                                                     logic [63:0] lvl);
      logic [63:0] sum;
      sum = (off * (64'(bsize) + 1)) << 16;
      if (lvl != 0) sum = sum + (c % (lvl << 16)) * 64'(bsize) / lvl;
      return sum[vbcl_pkg::COORD_W-1:0];
    endfunction

    function logic [63:0] flat_index(logic signed [vbcl_pkg::POS_W-1:0] p [3]);
      logic [63:0] d [3];
      logic [63:0] c [3];
      d[0] = 64'(dims[9:0]);
      d[1] = 64'(dims[19:10]);
      d[2] = 64'(dims[29:20]);
      if (d[0] == 0 || d[1] == 0 || d[2] == 0) return 64'(DEPTH);
      for (int a = 0; a < 3; a++) c[a] = cell_coord(p[a], a, d[a]);
      return ((c[2] >> 16) * d[1] + (c[1] >> 16)) * d[0] + (c[0] >> 16);
    endfunction

    function void note_request(vbcl_pkg::func_t f, logic [vbcl_pkg::INDEX_W-1:0] ti,
                               logic [vbcl_pkg::ENTRY_W-1:0] ed,
                               logic signed [vbcl_pkg::POS_W-1:0] p [3]);
      brick_rsp_t r;
      logic [63:0] d [3];
      logic [63:0] c [3];
      logic [63:0] idx;
      if (f == vbcl_pkg::FUNC_WRITE) begin
        if (ti < DEPTH) entries[ti] = ed;
        return;
      end
      r = '0;
      idx = flat_index(p);
      if (idx >= DEPTH) begin
        r.st = vbcl_pkg::ST_RANGE;
      end else begin
        d[0] = 64'(dims[9:0]);
        d[1] = 64'(dims[19:10]);
        d[2] = 64'(dims[29:20]);
        for (int a = 0; a < 3; a++) c[a] = cell_coord(p[a], a, d[a]);
        r.level = entries[idx][31:24];
        r.cx = tex_coord(c[0], 64'(entries[idx][7:0]), 64'(r.level));
        r.cy = tex_coord(c[1], 64'(entries[idx][15:8]), 64'(r.level));
        r.cz = tex_coord(c[2], 64'(entries[idx][23:16]), 64'(r.level));
        r.st = (r.level == 0) ? vbcl_pkg::ST_LEVEL_ZERO : vbcl_pkg::ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_response(brick_rsp_t got);
      brick_rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected x=%h y=%h z=%h lvl=%h st=%0d,",
                    " got x=%h y=%h z=%h lvl=%h st=%0d"},
                   want.cx, want.cy, want.cz, want.level, want.st,
                   got.cx, got.cy, got.cz, got.level, got.st);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic func = 1'b0;
  logic [vbcl_pkg::INDEX_W-1:0] table_index = '0;
  logic [vbcl_pkg::ENTRY_W-1:0] entry_data = '0;
  logic signed [vbcl_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [vbcl_pkg::COORD_W-1:0] brick_coord_x, brick_coord_y, brick_coord_z;
  logic [vbcl_pkg::LEVEL_W-1:0] entry_level;
  logic [vbcl_pkg::STATUS_W-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vbcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vbcl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  lookup_scoreboard sb = new();
  logic [DEPTH-1:0] written = '0;

  always #2 clk = ~clk;

  volume_brick_coordinate_lookup_unit u_top (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_response({brick_coord_x, brick_coord_y, brick_coord_z, entry_level, status});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(vbcl_pkg::cfg_reg_t r, logic [vbcl_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic send(vbcl_pkg::func_t f, logic [vbcl_pkg::INDEX_W-1:0] ti,
                      logic [vbcl_pkg::ENTRY_W-1:0] ed,
                      logic signed [vbcl_pkg::POS_W-1:0] px,
                      logic signed [vbcl_pkg::POS_W-1:0] py,
                      logic signed [vbcl_pkg::POS_W-1:0] pz);
    logic signed [vbcl_pkg::POS_W-1:0] p [3];
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    req_valid <= 1'b1;
    func <= f;
    table_index <= ti;
    entry_data <= ed;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(f, ti, ed, p);
    if (f == vbcl_pkg::FUNC_WRITE && ti < DEPTH) written[ti] = 1'b1;
  endtask

  // load the target entry first when a lookup would hit one never written
  task automatic lookup(logic signed [vbcl_pkg::POS_W-1:0] px,
                        logic signed [vbcl_pkg::POS_W-1:0] py,
                        logic signed [vbcl_pkg::POS_W-1:0] pz);
    logic signed [vbcl_pkg::POS_W-1:0] p [3];
    logic [63:0] idx;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    idx = sb.flat_index(p);
    if (idx < DEPTH && !written[idx[vbcl_pkg::INDEX_W-1:0]])
      send(vbcl_pkg::FUNC_WRITE, idx[vbcl_pkg::INDEX_W-1:0], $urandom, px, py, pz);
    send(vbcl_pkg::FUNC_LOOKUP, '0, '0, px, py, pz);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [vbcl_pkg::POS_W-1:0] rand_pos();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return v[vbcl_pkg::POS_W-1:0];
      1: return $signed(v[23:0]) - 24'sd4_000_000;
      2: return {1'b0, {(vbcl_pkg::POS_W-1){1'b1}}};
      default: return {1'b1, {(vbcl_pkg::POS_W-1){1'b0}}};
    endcase
  endfunction

  task automatic setup(logic [vbcl_pkg::DIMS_W-1:0] dims, logic [vbcl_pkg::SIZE_W-1:0] bs,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] sx,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] sy,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] sz,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] ox,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] oy,
                       logic [vbcl_pkg::CFG_DATA_W-1:0] oz);
    write_reg(vbcl_pkg::REG_ORIGIN_X, ox);
    write_reg(vbcl_pkg::REG_ORIGIN_Y, oy);
    write_reg(vbcl_pkg::REG_ORIGIN_Z, oz);
    write_reg(vbcl_pkg::REG_SCALE_X, sx);
    write_reg(vbcl_pkg::REG_SCALE_Y, sy);
    write_reg(vbcl_pkg::REG_SCALE_Z, sz);
    write_reg(vbcl_pkg::REG_GRID_DIMS, vbcl_pkg::CFG_DATA_W'(dims));
    write_reg(vbcl_pkg::REG_BRICK_SIZE, vbcl_pkg::CFG_DATA_W'(bs));
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send(vbcl_pkg::FUNC_WRITE, vbcl_pkg::INDEX_W'($urandom), $urandom,
             rand_pos(), rand_pos(), rand_pos());
      else
        lookup(rand_pos(), rand_pos(), rand_pos());
    end
  endtask

  initial begin
    logic signed [vbcl_pkg::POS_W-1:0] pmax, pmin;
    pmax = {1'b0, {(vbcl_pkg::POS_W-1){1'b1}}};
    pmin = {1'b1, {(vbcl_pkg::POS_W-1){1'b0}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 54;

    // zero grid dimension with reset registers
    lookup(40'sd65536, '0, '0);
    send(vbcl_pkg::FUNC_WRITE, 12'd0, 32'h00_010203, '0, '0, '0);
    send(vbcl_pkg::FUNC_WRITE, 12'd1, 32'hFF_FFFFFF, '0, '0, '0);
    send(vbcl_pkg::FUNC_WRITE, 12'd2, 32'h01_000000, '0, '0, '0);
    drain();

    // 16x16x16 grid, one cell per world unit
    setup({10'd16, 10'd16, 10'd16}, 6'd4, 42'h1_0000_0000, 42'h1_0000_0000,
          42'h1_0000_0000, '0, '0, '0);
    lookup(40'sd32768, '0, '0);
    lookup(-40'sd5, -40'sd5, -40'sd5);
    lookup(40'sd65536, 40'sd100, '0);
    lookup(40'sd131072 + 40'sd7000, '0, '0);
    lookup(pmax, pmax, pmax);
    lookup(pmin, pmax, pmin);
    send(vbcl_pkg::FUNC_WRITE, 12'hFFF, 32'hFFFF_FFFF, pmax, pmin, pmax);
    lookup(pmax, pmax, pmax);
    drain();

    // index beyond table and brick size extremes
    setup({10'd1023, 10'd1023, 10'd1023}, 6'd0, 42'h3FF_FFFF_FFFF, 42'h3FF_FFFF_FFFF,
          42'h3FF_FFFF_FFFF, {2'b11, pmin}, {2'b11, pmin}, {2'b00, pmax});
    lookup(pmax, pmax, pmax);
    lookup(pmin, pmin, pmin);
    lookup(pmax, pmin, pmin);
    drain();

    setup({10'd16, 10'd16, 10'd16}, 6'd63, 42'h1_0000_0000, 42'h0_8000_0000,
          42'h2_0000_0000, 42'h3F_FFF0_0000, '0, 42'h10_0000);
    random_items(400);
    send_idle_pct = 0;
    hold_cycles = 300;
    random_items(150);
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 14;
    setup({10'd8, 10'd32, 10'd16}, 6'd32, 42'h0_0002_0000, 42'h0_0004_0000,
          42'h0_0001_0000, 42'hFF_FF00_0000, 42'hFF_FF00_0000, 42'hFF_FF00_0000);
    random_items(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup({10'd1, 10'd64, 10'd64}, 6'd1, 42'h0_0000_1000, 42'h3FF_FFFF_FFFF,
          42'h0_0100_0000, '0, 42'hFF_0000_0000, 42'h00_FFFF_FFFF);
    random_items(300);
    drain();
    setup({10'd5, 10'd7, 10'd3}, 6'd17, vbcl_pkg::CFG_DATA_W'($urandom),
          vbcl_pkg::CFG_DATA_W'({$urandom, $urandom}),
          vbcl_pkg::CFG_DATA_W'({$urandom, $urandom}),
          vbcl_pkg::CFG_DATA_W'({$urandom, $urandom}),
          vbcl_pkg::CFG_DATA_W'({$urandom, $urandom}),
          vbcl_pkg::CFG_DATA_W'({$urandom, $urandom}));
    random_items(300);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
